// ----- hw/rtl/lrev_pkg.sv -----
// Shared types, constants and helpers for the bounded LIFO stack with reverse.
// Used by lrev_ctrl and bounded_lifo_stack_with_reverse_unit; depends on nothing.
`default_nettype none

package lrev_pkg;

  // Storage geometry
  localparam int DEPTH      = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_IN_W   = 7;
  localparam int CMP_W      = (CNT_W > CAP_IN_W) ? CNT_W : CAP_IN_W;

  // Port-level widths fixed by the interface
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;

  typedef logic [ITEM_WIDTH-1:0] item_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [COUNT_W-1:0]    count_t;

  // Action codes
  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_INVERT = 2'd3
  } action_t;

  // Request to the entry RAM
  typedef struct packed {
    logic  we;
    addr_t waddr;
    item_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  // One finished result
  typedef struct packed {
    word_t  item_out;
    logic   ok;
    count_t count;
    logic   is_empty;
    logic   is_full;
  } result_t;

  // Map a written capacity onto 1..DEPTH
  function automatic cnt_t clamp_capacity(input logic [CAP_IN_W-1:0] v);
    cmp_t ext;
    cmp_t res;
    ext = cmp_t'(v);
    if (ext == cmp_t'(0)) begin
      res = cmp_t'(1);
    end else if (ext > cmp_t'(DEPTH)) begin
      res = cmp_t'(DEPTH);
    end else begin
      res = ext;
    end
    return cnt_t'(res);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lrev_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
`default_nettype none

module lrev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lrev_ctrl.sv -----
// Sequencer of the LIFO stack: fill count, shared step adder, swap walk.
// Depends on lrev_pkg; drives the entry RAM through a ram_req_t request.
`default_nettype none

module lrev_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input transaction
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_action,
  input  wire logic [31:0]       in_item_value,
  // clamped capacity
  input  wire lrev_pkg::cnt_t    cap_i,
  // entry RAM
  output lrev_pkg::ram_req_t     ram_req_o,
  input  wire lrev_pkg::item_t   ram_rdata_i,
  // result toward the output register
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output lrev_pkg::result_t      res_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WAIT = 7'b0000010,
    S_READ = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_RD_B = 7'b0010000,
    S_WR_A = 7'b0100000,
    S_WR_B = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  lrev_pkg::cnt_t    fill_r, fill_nxt;
  lrev_pkg::cnt_t    lo_r, lo_nxt;
  lrev_pkg::cnt_t    hi_r, hi_nxt;
  lrev_pkg::item_t   tmp_r, tmp_nxt;
  logic              ok_r, ok_nxt;

  // shared step unit: operand plus or minus one
  lrev_pkg::cnt_t    step_a;
  logic              step_dec;
  lrev_pkg::cnt_t    step_sum;

  lrev_pkg::action_t act;
  logic              can_push;

  assign act      = lrev_pkg::action_t'(in_action);
  assign can_push = (fill_r < cap_i);
  assign step_sum = step_dec ? (step_a - lrev_pkg::cnt_t'(1)) : (step_a + lrev_pkg::cnt_t'(1));
  assign in_ready = (state_r == S_IDLE);

  // Sequence one action
  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    tmp_nxt     = tmp_r;
    ok_nxt      = ok_r;
    step_a      = fill_r;
    step_dec    = 1'b0;
    ram_req_o   = '0;
    res_valid_o = 1'b0;

    case (state_r)
      S_IDLE: begin
        step_a   = fill_r;
        step_dec = (act != lrev_pkg::ACT_PUSH);
        if (in_valid) begin
          case (act)
            lrev_pkg::ACT_PUSH: begin
              ok_nxt    = can_push;
              state_nxt = S_WAIT;
              if (can_push) begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = fill_r[lrev_pkg::ADDR_W-1:0];
                ram_req_o.wdata = lrev_pkg::item_t'(in_item_value);
                fill_nxt        = step_sum;
              end
            end
            lrev_pkg::ACT_POP,
            lrev_pkg::ACT_PEEK: begin
              if (fill_r != '0) begin
                ok_nxt          = 1'b1;
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = step_sum[lrev_pkg::ADDR_W-1:0];
                state_nxt       = S_READ;
                if (act == lrev_pkg::ACT_POP) begin
                  fill_nxt = step_sum;
                end
              end else begin
                ok_nxt    = 1'b0;
                state_nxt = S_WAIT;
              end
            end
            lrev_pkg::ACT_INVERT: begin
              ok_nxt    = 1'b1;
              lo_nxt    = '0;
              hi_nxt    = fill_r;
              state_nxt = S_CHK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Result without read data: hold until the output slot frees
      S_WAIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_nxt = S_IDLE;
        end
      end

      // Result carrying the read entry
      S_READ: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_nxt = S_IDLE;
        end
      end

      // Step hi down; swap while hi-1 still lies above lo
      S_CHK: begin
        step_a   = hi_r;
        step_dec = 1'b1;
        if ((hi_r != '0) && (step_sum > lo_r)) begin
          hi_nxt          = step_sum;
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = lo_r[lrev_pkg::ADDR_W-1:0];
          state_nxt       = S_RD_B;
        end else begin
          state_nxt = S_WAIT;
        end
      end

      // Keep the low entry, fetch the high one
      S_RD_B: begin
        tmp_nxt         = ram_rdata_i;
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = hi_r[lrev_pkg::ADDR_W-1:0];
        state_nxt       = S_WR_A;
      end

      // High entry goes to the low slot
      S_WR_A: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = lo_r[lrev_pkg::ADDR_W-1:0];
        ram_req_o.wdata = ram_rdata_i;
        state_nxt       = S_WR_B;
      end

      // Low entry goes to the high slot; advance lo
      S_WR_B: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = hi_r[lrev_pkg::ADDR_W-1:0];
        ram_req_o.wdata = tmp_r;
        step_a          = lo_r;
        step_dec        = 1'b0;
        lo_nxt          = step_sum;
        state_nxt       = S_CHK;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result fields
  always_comb begin
    res_o.item_out = (state_r == S_READ) ? lrev_pkg::word_t'(ram_rdata_i) : '0;
    res_o.ok       = ok_r;
    res_o.count    = lrev_pkg::count_t'(fill_r);
    res_o.is_empty = (fill_r == '0);
    res_o.is_full  = (fill_r >= cap_i);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tmp_r <= tmp_nxt;
    ok_r  <= ok_nxt;
  end

  // Fill never passes the storage depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= lrev_pkg::cnt_t'(lrev_pkg::DEPTH))
    else $error("fill count above depth");

  // The RAM never sees a read and a write in the same cycle
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req_o.we && ram_req_o.re))
    else $error("RAM read and write in one cycle");

  // A successful push grows the fill by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (act == lrev_pkg::ACT_PUSH) && can_push)
    |=> (fill_r == $past(fill_r) + lrev_pkg::cnt_t'(1)))
    else $error("push did not grow fill");

  // Fill only moves on an accepted transaction
  a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(fill_r))
    else $error("fill changed while busy");

  // Swap pointers stay ordered during a swap
  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RD_B) || (state_r == S_WR_A) || (state_r == S_WR_B))
    |-> (lo_r < hi_r))
    else $error("swap pointers crossed");

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_lifo_stack_with_reverse_unit.sv -----
// Top level of the bounded LIFO stack with reverse: capacity register,
// output register, entry RAM and sequencer. Depends on lrev_pkg, lrev_ram, lrev_ctrl.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------------
//   in       | in_valid / in_ready   | in_action[1:0], in_item_value[31:0]
//   out      | out_valid / out_ready | out_item_out[31:0], out_ok, out_count[6:0],
//            |                       | out_is_empty, out_is_full
//   cfg      | cfg_valid / cfg_ready | cfg_capacity[6:0]
//
// Push, pop and peek make at most one RAM access, then the result moves to the output.
// Invert swaps entries from both ends toward the middle: each swap is two reads and two writes
// through the single read and single write port of the entry RAM.
// in_ready is high only while the sequencer is idle; a result waiting on out_ready
// does not block the next transaction, but that one's result waits for the slot.
// Reset (synchronous, rst_n low) empties the stack and sets capacity to its maximum.
`default_nettype none

module bounded_lifo_stack_with_reverse_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_item_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] out_item_out,
  output logic             out_ok,
  output logic      [6:0]  out_count,
  output logic             out_is_empty,
  output logic             out_is_full,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_capacity
);

  lrev_pkg::cnt_t     cap_r, cap_nxt;
  lrev_pkg::ram_req_t ram_req;
  lrev_pkg::item_t    ram_rdata;
  lrev_pkg::result_t  res;
  logic               res_valid;
  logic               slot_free;
  logic               out_valid_r, out_valid_nxt;
  lrev_pkg::result_t  out_r, out_nxt;

  // Capacity register, clamped on write
  assign cfg_ready = 1'b1;
  assign cap_nxt   = (cfg_valid && cfg_ready) ? lrev_pkg::clamp_capacity(cfg_capacity) : cap_r;

  // Output register: load a finished result when the slot is free
  assign slot_free     = !out_valid_r || out_ready;
  assign out_valid_nxt = (res_valid && slot_free) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_nxt       = (res_valid && slot_free) ? res : out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= lrev_pkg::clamp_capacity(lrev_pkg::CAP_IN_W'(64));
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_item_out = out_r.item_out;
  assign out_ok       = out_r.ok;
  assign out_count    = out_r.count;
  assign out_is_empty = out_r.is_empty;
  assign out_is_full  = out_r.is_full;

  // Entry storage
  lrev_ram #(
    .WIDTH (lrev_pkg::ITEM_WIDTH),
    .DEPTH (lrev_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Sequencer
  lrev_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_item_value (in_item_value),
    .cap_i         (cap_r),
    .ram_req_o     (ram_req),
    .ram_rdata_i   (ram_rdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (slot_free),
    .res_o         (res)
  );

endmodule

`default_nettype wire
